>>> rtl/hds_pkg.sv
// Shared types and constants for the heat diffusion stencil pass unit.
// No dependencies; design files refer to this package by scoped names, testbenches import it.
package hds_pkg;

  // Field and register widths
  localparam int CELL_W     = 16;
  localparam int SUM_W      = CELL_W + 2;   // sum of four neighbours
  localparam int ALPHA_W    = 16;
  localparam int WC_W       = ALPHA_W + 3;  // 1 - 4a in Q2.16, signed
  localparam int COLS_W     = 8;
  localparam int ROWS_W     = 16;
  localparam int CNT_W      = 24;           // emitted result count
  localparam int PROD_W     = WC_W + CELL_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FRAC_W     = 16;

  // Defaults
  localparam int MAX_COLUMNS = 128;
  localparam int ALPHA_RST   = 16384;
  localparam int COLUMNS_RST = 100;
  localparam int ROWS_RST    = 100;
  localparam int MIN_SIZE    = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA   = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_ROWS    = 2'd2
  } cfg_idx_e;

  // Operands of one interior update, handed from the raster front end to the
  // arithmetic pipeline
  typedef struct packed {
    logic signed [CELL_W-1:0] centre;
    logic signed [SUM_W-1:0]  nsum;
    logic                     border;
    logic                     last;
  } tap_t;

endpackage

>>> rtl/hds_cell_if.sv
// Input channel of the heat diffusion stencil pass unit: one raster cell or a
// flush per transaction. Depends on hds_pkg for field widths.
interface hds_cell_if;
  logic                             valid;
  logic                             ready;
  logic signed [hds_pkg::CELL_W-1:0] cell_value;
  logic                             flush;

  modport source (output valid, cell_value, flush, input ready);
  modport sink   (input valid, cell_value, flush, output ready);
endinterface

>>> rtl/hds_result_if.sv
// Output channel of the heat diffusion stencil pass unit: one updated cell per
// transaction. Depends on hds_pkg for field widths.
interface hds_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [hds_pkg::CELL_W-1:0] new_value;
  logic                             grid_last;

  modport source (output valid, new_value, grid_last, input ready);
  modport sink   (input valid, new_value, grid_last, output ready);
endinterface

>>> rtl/hds_raster_ctrl.sv
// Raster front end: line buffer memory, four-cell window, raster position and
// result count. Depends on hds_pkg and hds_cell_if.
module hds_raster_ctrl #(
  parameter int  MaxColumns = hds_pkg::MAX_COLUMNS,
  localparam int ColW       = $clog2(MaxColumns),
  localparam int CntW       = $clog2(MaxColumns + 1),
  localparam int TotW       = hds_pkg::ROWS_W + CntW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  logic [CntW-1:0]            eff_cols_i,
  input  logic [hds_pkg::ROWS_W-1:0] eff_rows_i,
  input  logic [TotW-1:0]            total_i,
  hds_cell_if.sink                   cell_i,
  output hds_pkg::tap_t              tap_o,
  output logic                       tap_valid_o,
  input  logic                       tap_ready_i
);

  localparam int CmpW  = (TotW > hds_pkg::CNT_W) ? TotW : hds_pkg::CNT_W;
  localparam int CW    = hds_pkg::CELL_W;
  localparam int SW    = hds_pkg::SUM_W;

  // Line buffer entry: older row in the upper half, previous row below
  logic [2*CW-1:0] lb_mem [MaxColumns];
  logic [2*CW-1:0] rd_q;
  logic [2*CW-1:0] wr_data;
  logic            wr_en;

  logic [ColW-1:0]            col_q, col_d;
  logic [hds_pkg::ROWS_W-1:0] row_q, row_d;
  logic [hds_pkg::CNT_W-1:0]  emitted_q, emitted_d, cnt_inc;

  // Window: up, centre, down of the newest column and centre of the one before
  logic signed [CW-1:0] win_up_q, win_ctr_q, win_dn_q, win_left_q;
  logic signed [CW-1:0] win_up_d, win_ctr_d, win_dn_d, win_left_d;

  hds_pkg::tap_t tap_q, tap_d;
  logic          tap_v_q, tap_v_d;

  logic                 take, draining, noop, step, emit, grid_end, is_last, clear;
  logic [CntW-1:0]      col_inc;
  logic                 col_wrap;
  logic signed [CW-1:0] mid, top, x;

  // Line buffer: read one column ahead, forward a write to the same entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lb_mem[col_q] <= wr_data;
    end
    if (wr_en && (col_q == col_d)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= lb_mem[col_d];
    end
  end

  // Decode the transaction against the raster position
  always_comb begin
    take     = cell_i.valid && cell_i.ready;
    draining = row_q >= eff_rows_i;
    noop     = cell_i.flush && !draining;
    step     = take && !noop;
    emit     = ((row_q != '0) && (col_q != '0)) || (row_q >= hds_pkg::ROWS_W'(2));
    mid      = $signed(rd_q[CW-1:0]);
    top      = $signed(rd_q[2*CW-1:CW]);
    x        = draining ? '0 : cell_i.cell_value;
    col_inc  = CntW'(col_q) + CntW'(1);
    col_wrap = col_inc >= eff_cols_i;
    cnt_inc  = emitted_q + hds_pkg::CNT_W'(1);
    is_last  = CmpW'(cnt_inc) == CmpW'(total_i);
    grid_end = step && emit && is_last;
    clear    = restart_i || grid_end;
    wr_en    = step;
    wr_data  = {mid, x};
  end

  // Clear on restart or grid end, else advance position, count and window
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    emitted_d  = emitted_q;
    win_up_d   = win_up_q;
    win_ctr_d  = win_ctr_q;
    win_dn_d   = win_dn_q;
    win_left_d = win_left_q;
    if (clear) begin
      col_d      = '0;
      row_d      = '0;
      emitted_d  = '0;
      win_up_d   = '0;
      win_ctr_d  = '0;
      win_dn_d   = '0;
      win_left_d = '0;
    end else if (step) begin
      col_d      = col_wrap ? '0 : col_inc[ColW-1:0];
      if (col_wrap && (row_q < eff_rows_i)) begin
        row_d = row_q + hds_pkg::ROWS_W'(1);
      end
      if (emit) begin
        emitted_d = cnt_inc;
      end
      win_left_d = win_ctr_q;
      win_up_d   = top;
      win_ctr_d  = mid;
      win_dn_d   = x;
    end
  end

  // Hold the operand stage until the pipeline takes it
  always_comb begin
    cell_i.ready = !tap_v_q || tap_ready_i;
    tap_v_d      = tap_v_q;
    tap_d        = tap_q;
    if (cell_i.ready) begin
      tap_v_d = step && emit;
    end
    if (step && emit) begin
      tap_d.centre = win_ctr_q;
      tap_d.nsum   = SW'(win_left_q) + SW'(mid) + SW'(win_up_q) + SW'(win_dn_q);
      tap_d.border = (col_q <= ColW'(1)) || (row_q == hds_pkg::ROWS_W'(1)) || draining;
      tap_d.last   = is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      emitted_q  <= '0;
      win_up_q   <= '0;
      win_ctr_q  <= '0;
      win_dn_q   <= '0;
      win_left_q <= '0;
      tap_v_q    <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      emitted_q  <= emitted_d;
      win_up_q   <= win_up_d;
      win_ctr_q  <= win_ctr_d;
      win_dn_q   <= win_dn_d;
      win_left_q <= win_left_d;
      tap_v_q    <= tap_v_d;
    end
  end

  // Operand payload
  always_ff @(posedge clk_i) begin
    tap_q <= tap_d;
  end

  assign tap_o       = tap_q;
  assign tap_valid_o = tap_v_q;

endmodule

>>> rtl/hds_stencil_pipe.sv
// Arithmetic pipeline: weighted centre and neighbour products, round to
// nearest, saturate, output register. Depends on hds_pkg and hds_result_if.
module hds_stencil_pipe (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [hds_pkg::ALPHA_W-1:0]       alpha_i,
  input  logic signed [hds_pkg::WC_W-1:0]   wc_i,
  input  hds_pkg::tap_t                     tap_i,
  input  logic                              tap_valid_i,
  output logic                              tap_ready_o,
  hds_result_if.source                      result_o
);

  localparam int PW = hds_pkg::PROD_W;
  localparam int AW = hds_pkg::ACC_W;
  localparam int CW = hds_pkg::CELL_W;
  localparam int QW = AW - hds_pkg::FRAC_W;

  logic signed [PW-1:0] prod_c_q, prod_s_q;
  logic signed [CW-1:0] centre_q;
  logic                 border_q, last_q, s2_v_q;

  logic signed [CW-1:0] out_val_q, out_val_d;
  logic                 out_last_q, out_v_q;

  logic                 out_en, s2_en;
  logic signed [AW-1:0] acc;
  logic signed [QW-1:0] quo;
  logic [QW-CW:0]       hi;
  logic signed [CW-1:0] sat;

  // Stage enables: a stage loads when it is empty or its successor moves
  assign out_en      = !out_v_q || result_o.ready;
  assign s2_en       = !s2_v_q || out_en;
  assign tap_ready_o = s2_en;

  // Round to nearest (ties upward), then clamp to 16 bits
  always_comb begin
    acc = {{(AW-PW){prod_c_q[PW-1]}}, prod_c_q} + {{(AW-PW){prod_s_q[PW-1]}}, prod_s_q}
          + AW'(32768);
    quo = acc[AW-1:hds_pkg::FRAC_W];
    hi  = quo[QW-1:CW-1];
    if ((&hi) || !(|hi)) begin
      sat = quo[CW-1:0];
    end else if (quo[QW-1]) begin
      sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(CW-1){1'b1}}};
    end
    out_val_d = border_q ? centre_q : sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_v_q <= tap_valid_i;
      end
      if (out_en) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // Products, one multiplier each, registered; then the output register
  always_ff @(posedge clk_i) begin
    if (s2_en && tap_valid_i) begin
      prod_c_q <= wc_i * tap_i.centre;
      prod_s_q <= $signed({1'b0, alpha_i}) * tap_i.nsum;
      centre_q <= tap_i.centre;
      border_q <= tap_i.border;
      last_q   <= tap_i.last;
    end
    if (out_en && s2_v_q) begin
      out_val_q  <= out_val_d;
      out_last_q <= last_q;
    end
  end

  assign result_o.valid     = out_v_q;
  assign result_o.new_value = out_val_q;
  assign result_o.grid_last = out_last_q;

endmodule

>>> rtl/heat_diffusion_stencil_pass_unit.sv
// Heat diffusion stencil pass unit: one explicit FTCS step of the 2D heat
// equation on a raster stream. Depends on hds_pkg, the channel interfaces,
// hds_raster_ctrl and hds_stencil_pipe.
// Throughput: one transaction per cycle unless the result channel stalls, set by one line
// buffer read and write per column. A result passes the operand, product and output registers
// after the transaction that releases it, which trails its own cell by one row plus one cell.
// Reset clears position, window, count and pipeline; line buffers are not cleared.
module heat_diffusion_stencil_pass_unit #(
  parameter int MaxColumns = hds_pkg::MAX_COLUMNS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hds_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  hds_cell_if.sink                       cell_i,
  hds_result_if.source                   result_o
);

  localparam int CntW    = $clog2(MaxColumns + 1);
  localparam int TotW    = hds_pkg::ROWS_W + CntW;
  localparam int ColsRst = (hds_pkg::COLUMNS_RST > MaxColumns) ? MaxColumns
                                                              : hds_pkg::COLUMNS_RST;
  localparam int TotRst  = hds_pkg::ROWS_RST * ColsRst;
  localparam int WcRst   = 65536 - 4 * hds_pkg::ALPHA_RST;

  logic [hds_pkg::ALPHA_W-1:0]     alpha_q, alpha_d;
  logic signed [hds_pkg::WC_W-1:0] wc_q, wc_d;
  logic [CntW-1:0]                 eff_cols_q, eff_cols_d;
  logic [hds_pkg::ROWS_W-1:0]      eff_rows_q, eff_rows_d;
  logic [TotW-1:0]                 total_q;
  logic                            restart;
  logic [hds_pkg::COLS_W-1:0]      cols_w;

  hds_pkg::tap_t tap;
  logic          tap_valid, tap_ready;

  // Decode configuration writes and clamp grid sizes
  always_comb begin
    alpha_d    = alpha_q;
    wc_d       = wc_q;
    eff_cols_d = eff_cols_q;
    eff_rows_d = eff_rows_q;
    restart    = 1'b0;
    cols_w     = cfg_wdata_i[hds_pkg::COLS_W-1:0];
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hds_pkg::CFG_ALPHA: begin
          alpha_d = cfg_wdata_i;
          wc_d    = $signed(hds_pkg::WC_W'(65536)) - $signed({1'b0, cfg_wdata_i, 2'b00});
        end
        hds_pkg::CFG_COLUMNS: begin
          restart = 1'b1;
          if (int'(cols_w) < hds_pkg::MIN_SIZE) begin
            eff_cols_d = CntW'(hds_pkg::MIN_SIZE);
          end else if (int'(cols_w) > MaxColumns) begin
            eff_cols_d = CntW'(MaxColumns);
          end else begin
            eff_cols_d = CntW'(cols_w);
          end
        end
        hds_pkg::CFG_ROWS: begin
          restart    = 1'b1;
          eff_rows_d = (int'(cfg_wdata_i) < hds_pkg::MIN_SIZE)
                       ? hds_pkg::ROWS_W'(hds_pkg::MIN_SIZE) : cfg_wdata_i;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= hds_pkg::ALPHA_W'(hds_pkg::ALPHA_RST);
      wc_q       <= hds_pkg::WC_W'(WcRst);
      eff_cols_q <= CntW'(ColsRst);
      eff_rows_q <= hds_pkg::ROWS_W'(hds_pkg::ROWS_RST);
      total_q    <= TotW'(TotRst);
    end else begin
      alpha_q    <= alpha_d;
      wc_q       <= wc_d;
      eff_cols_q <= eff_cols_d;
      eff_rows_q <= eff_rows_d;
      // Cells per grid, refreshed every cycle from the clamped sizes
      total_q    <= TotW'(eff_rows_q) * TotW'(eff_cols_q);
    end
  end

  hds_raster_ctrl #(
    .MaxColumns (MaxColumns)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .eff_cols_i  (eff_cols_q),
    .eff_rows_i  (eff_rows_q),
    .total_i     (total_q),
    .cell_i      (cell_i),
    .tap_o       (tap),
    .tap_valid_o (tap_valid),
    .tap_ready_i (tap_ready)
  );

  hds_stencil_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .alpha_i     (alpha_q),
    .wc_i        (wc_q),
    .tap_i       (tap),
    .tap_valid_i (tap_valid),
    .tap_ready_o (tap_ready),
    .result_o    (result_o)
  );

endmodule

>>> test/tb_hds_stencil_check.sv
`timescale 1ns / 1ps
// Checker for the heat diffusion stencil pass unit: watches the configuration
// port and both channels, predicts each updated cell and compares it.
// Depends on hds_pkg, hds_cell_if and hds_result_if.
module tb_hds_stencil_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hds_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  hds_cell_if                            cell_i,
  hds_result_if                          result_i,
  output int                             pending_o,
  output int                             errors_o
);
  import hds_pkg::*;

  localparam int MaxReported = 10;
  localparam longint SatHi   = 32767;
  localparam longint SatLo   = -32768;

  typedef logic signed [CELL_W-1:0] cell_t;

  typedef struct {
    cell_t value;
    logic  last;
  } updated_cell_t;

  // Predicted block state
  cell_t              row_above [MAX_COLUMNS];  // row before the previous one
  cell_t              row_prev  [MAX_COLUMNS];  // previous row
  cell_t              win       [6];            // newest column, then the one before
  int                 col_idx;
  int                 row_idx;
  logic [CNT_W-1:0]   emitted;
  logic [ALPHA_W-1:0] alpha_q;
  logic [COLS_W-1:0]  columns_q;
  logic [ROWS_W-1:0]  rows_q;

  updated_cell_t updated_cells_q[$];

  // Clear raster position, count and window
  function automatic void restart_grid();
    col_idx = 0;
    row_idx = 0;
    emitted = '0;
    foreach (win[k]) win[k] = '0;
  endfunction

  // (1-4a)*u + a*(sum of neighbours), round half up, saturate
  function automatic cell_t ftcs_update(input cell_t ctr, input cell_t lft,
                                        input cell_t rgt, input cell_t up,
                                        input cell_t dn);
    longint wc;
    longint nsum;
    longint acc;
    longint q;
    wc   = 65536 - 4 * longint'(alpha_q);
    nsum = longint'(lft) + longint'(rgt) + longint'(up) + longint'(dn);
    acc  = wc * longint'(ctr) + longint'(alpha_q) * nsum + 32768;
    q    = acc >>> FRAC_W;
    if (q > SatHi) q = SatHi;
    if (q < SatLo) q = SatLo;
    return cell_t'(q);
  endfunction

  // Advance the raster by one accepted transaction; queue any result
  task automatic advance_raster(input cell_t cell_in, input logic flush);
    int            cc;
    int            rr;
    int            c;
    int            r;
    logic          draining;
    logic          emit;
    logic          border;
    cell_t         x;
    cell_t         top;
    cell_t         mid;
    updated_cell_t res;
    cc = (columns_q < MIN_SIZE) ? MIN_SIZE :
         (columns_q > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_q);
    rr = (rows_q < MIN_SIZE) ? MIN_SIZE : int'(rows_q);
    draining = row_idx >= rr;
    // flush before the grid is complete: nothing happens
    if (flush && !draining) return;
    c = (col_idx >= cc) ? 0 : col_idx;
    r = row_idx;
    x = draining ? cell_t'(0) : cell_in;
    top = row_above[c];
    mid = row_prev[c];
    emit = (r >= 1 && c >= 1) || r >= 2;
    res.value = '0;
    res.last  = 1'b0;
    if (emit) begin
      border = c <= 1 || r == 1 || draining;
      res.value = border ? win[1] : ftcs_update(win[1], win[4], mid, win[0], win[2]);
    end
    // shift the window and the line buffers
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = x;
    row_above[c] = mid;
    row_prev[c]  = x;
    c++;
    if (c >= cc) begin
      c = 0;
      if (r < rr) r++;
    end
    col_idx = c;
    row_idx = r;
    if (emit) begin
      emitted = emitted + 1'b1;
      if (emitted == CNT_W'(rr * cc)) begin
        res.last = 1'b1;
        restart_grid();
      end
      updated_cells_q.push_back(res);
    end
  endtask

  // Compare one result transaction with the oldest prediction
  task automatic compare_result(input cell_t value, input logic last);
    updated_cell_t exp;
    if (updated_cells_q.size() == 0) begin
      errors_o++;
      if (errors_o <= MaxReported)
        $display("%0t: unexpected result value %0d last %0b", $time, value, last);
      return;
    end
    exp = updated_cells_q.pop_front();
    if (exp.value !== value || exp.last !== last) begin
      errors_o++;
      if (errors_o <= MaxReported)
        $display("%0t: mismatch: expected value %0d last %0b, got value %0d last %0b",
                 $time, exp.value, exp.last, value, last);
    end
  endtask

  // Track configuration, inputs and outputs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (row_above[k]) row_above[k] = '0;
      foreach (row_prev[k]) row_prev[k] = '0;
      alpha_q   = ALPHA_W'(ALPHA_RST);
      columns_q = COLS_W'(COLUMNS_RST);
      rows_q    = ROWS_W'(ROWS_RST);
      restart_grid();
      updated_cells_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ALPHA: alpha_q = cfg_wdata_i[ALPHA_W-1:0];
          CFG_COLUMNS: begin
            columns_q = cfg_wdata_i[COLS_W-1:0];
            restart_grid();
          end
          CFG_ROWS: begin
            rows_q = cfg_wdata_i[ROWS_W-1:0];
            restart_grid();
          end
          default: ;
        endcase
      end
      if (cell_i.valid && cell_i.ready)
        advance_raster(cell_i.cell_value, cell_i.flush);
      if (result_i.valid && result_i.ready)
        compare_result(result_i.new_value, result_i.grid_last);
      pending_o = updated_cells_q.size();
    end
  end

endmodule

>>> test/tb_heat_diffusion_stencil_pass_unit.sv
`timescale 1ns / 1ps
// Testbench top for the heat diffusion stencil pass unit: clock, reset,
// directed and random grids, idling on both channels and the verdict.
// Depends on hds_pkg, the channel interfaces and tb_hds_stencil_check.
module tb_heat_diffusion_stencil_pass_unit;
  import hds_pkg::*;

  localparam int NumItems   = 1750;
  localparam int DrainSlack = 8;
  localparam int CellMax    = 32767;
  localparam int CellMin    = -32768;

  typedef logic signed [CELL_W-1:0] cell_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    pending;
  int                    errors;
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  int                    items_sent;

  hds_cell_if   cell_ch ();
  hds_result_if result_ch ();

  heat_diffusion_stencil_pass_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .cell_i     (cell_ch),
    .result_o   (result_ch)
  );

  tb_hds_stencil_check i_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .cell_i     (cell_ch),
    .result_i   (result_ch),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #3ms;
    $display("tb_heat_diffusion_stencil_pass_unit: errors");
    $finish;
  end

  // Receiver: stall at random
  always @(posedge clk_i) begin
    result_ch.ready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  // Extremes or small values in three draws of eight, the rest full range
  function automatic cell_t rand_cell();
    logic [CELL_W-1:0] r;
    case ($urandom_range(7))
      0: r = CELL_W'(CellMax);
      1: r = CELL_W'(CellMin);
      2: r = CELL_W'($urandom_range(16)) - CELL_W'(8);
      default: r = CELL_W'($urandom());
    endcase
    return cell_t'(r);
  endfunction

  // Offer one transaction, idling before it at random
  task automatic send_item(input cell_t value, input logic flush, input bit counted);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      cell_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    cell_ch.valid      <= 1'b1;
    cell_ch.cell_value <= value;
    cell_ch.flush      <= flush;
    @(posedge clk_i);
    while (!cell_ch.ready) @(posedge clk_i);
    if (counted) items_sent++;
    // idling profile: sender light, then receiver light, then none
    if (items_sent < NumItems / 3) begin
      tx_idle_pct = 30;
      rx_idle_pct = 50;
    end else if (items_sent < 2 * NumItems / 3) begin
      tx_idle_pct = 50;
      rx_idle_pct = 30;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // Hold the sender until every predicted result has arrived
  task automatic settle();
    cell_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stream one grid: noise flushes while filling, a mix of flushes and
  // dropped cells while draining; a cap below the cell count aborts it
  task automatic run_grid(input int ncols, input int nrows, input int cap,
                          input bit force_pause);
    int total;
    int sent;
    int pause_at;
    total    = ncols * nrows;
    sent     = 0;
    pause_at = (force_pause || $urandom_range(9) == 0) ? $urandom_range(1, total) : -1;
    while (sent < total && sent < cap) begin
      if ($urandom_range(99) < 4) begin
        send_item(rand_cell(), 1'b1, 1'b0);
      end else begin
        send_item(rand_cell(), 1'b0, 1'b1);
        sent++;
        if (sent == pause_at) settle();
      end
    end
    if (sent == total) begin
      repeat (ncols + 1) send_item(rand_cell(), $urandom_range(99) < 70, 1'b1);
    end
  endtask

  // Stimulus
  initial begin
    int               grid_no;
    int               cols;
    int               rows;
    int               cap;
    int               effc;
    int               effr;
    logic [ALPHA_W-1:0] alpha;

    rst_ni             = 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_ALPHA;
    cfg_wdata          <= '0;
    cell_ch.valid      <= 1'b0;
    cell_ch.cell_value <= '0;
    cell_ch.flush      <= 1'b0;
    tx_idle_pct        = 30;
    rx_idle_pct        = 50;
    items_sent         = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Early flush at reset sizes: ignored
    send_item(cell_t'(16'h1234), 1'b1, 1'b0);
    settle();

    // Most negative centre weight, checkerboard of extremes: saturation
    cfg_write(CFG_ALPHA, 16'hFFFF);
    cfg_write(CFG_COLUMNS, 16'd3);
    cfg_write(CFG_ROWS, 16'd3);
    for (int i = 0; i < 9; i++)
      send_item((i % 2 == 0) ? cell_t'(CellMax) : cell_t'(CellMin), 1'b0, 1'b1);
    send_item('0, 1'b1, 1'b1);
    send_item('0, 1'b1, 1'b1);
    send_item(cell_t'(CellMax), 1'b0, 1'b1);   // cell while draining
    send_item('0, 1'b1, 1'b1);
    settle();

    // Half weight, a single unit neighbour gives an exact tie; sizes below minimum
    cfg_write(CFG_ALPHA, 16'h8000);
    cfg_write(CFG_COLUMNS, 16'd1);
    cfg_write(CFG_ROWS, 16'd0);
    for (int i = 0; i < 9; i++)
      send_item((i == 1) ? cell_t'(1) : cell_t'(0), 1'b0, 1'b1);
    repeat (4) send_item('0, 1'b1, 1'b1);

    // Random grids, with reset values and the largest sizes at fixed slots
    grid_no = 0;
    while (items_sent < NumItems) begin
      settle();
      cap = -1;
      if (grid_no == 1) begin
        alpha = ALPHA_W'(ALPHA_RST);
        cols  = COLUMNS_RST;
        rows  = ROWS_RST;
        cap   = 230;
      end else if (grid_no == 4) begin
        alpha = ALPHA_W'($urandom_range(65535));
        cols  = 255;
        rows  = 3;
      end else if (grid_no == 7) begin
        alpha = 16'd0;
        cols  = MAX_COLUMNS;
        rows  = 65535;
        cap   = 300;
      end else begin
        case ($urandom_range(4))
          0: alpha = 16'd0;
          1: alpha = 16'hFFFF;
          2: alpha = ALPHA_W'(ALPHA_RST);
          default: alpha = ALPHA_W'($urandom_range(65535));
        endcase
        cols = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
        rows = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
      end
      effc = (cols < MIN_SIZE) ? MIN_SIZE : (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
      effr = (rows < MIN_SIZE) ? MIN_SIZE : rows;
      if (cap < 0)
        cap = ($urandom_range(99) < 15) ? $urandom_range(1, effc * effr - 1) : effc * effr;
      cfg_write(CFG_ALPHA, alpha);
      cfg_write(CFG_COLUMNS, CFG_DATA_W'(cols));
      cfg_write(CFG_ROWS, CFG_DATA_W'(rows));
      run_grid(effc, effr, cap, grid_no == 0);
      grid_no++;
    end

    // Drain and give the verdict
    settle();
    if (errors == 0 && pending == 0) begin
      $display("tb_heat_diffusion_stencil_pass_unit: clean");
    end else begin
      $display("tb_heat_diffusion_stencil_pass_unit: errors");
    end
    $finish;
  end

endmodule

>>> heat_diffusion_stencil_pass_unit.f
rtl/hds_pkg.sv
rtl/hds_cell_if.sv
rtl/hds_result_if.sv
rtl/hds_raster_ctrl.sv
rtl/hds_stencil_pipe.sv
rtl/heat_diffusion_stencil_pass_unit.sv
test/tb_hds_stencil_check.sv
test/tb_heat_diffusion_stencil_pass_unit.sv
